### src/buddy_block_allocator_defines.svh
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// cond must never hold outside reset
`define BBA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// cause is followed in the next cycle by effect
`define BBA_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

### src/bba_pkg.sv
package bba_pkg;

  localparam int POOL_ORDER_DEF = 10;
  localparam int ORD_W = 5;
  localparam int MAX_W = 17;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_LARGE   = 3'd2;
  localparam logic [2:0] ST_NOSPACE = 3'd3;
  localparam logic [2:0] ST_BADFREE = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_FIND,
    OP_DREAD,
    OP_DSEL,
    OP_SAVE,
    OP_UREAD,
    OP_UWR,
    OP_SPREP,
    OP_SRIGHT,
    OP_SLEFT,
    OP_SLEAF,
    OP_FSTART,
    OP_MZB,
    OP_MZH,
    OP_MFIN,
    OP_SETERR,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic zero;
    logic too_big;
    logic tag_bad;
    logic root_has;
    logic k_eq_tgt;
    logic k_top;
    logic k_eq_want;
    logic buddy_free;
  } dp_stat_t;

  // order of the smallest power of two not below a nonzero size
  function automatic logic [ORD_W-1:0] ceil_log2(input logic [15:0] size);
    logic [15:0] v;
    logic [ORD_W-1:0] r;
    v = size - 16'd1;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) r = ORD_W'(i + 1);
    end
    return r;
  endfunction

  function automatic logic [ORD_W-1:0] lowest_bit(input logic [MAX_W-1:0] v);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int i = MAX_W - 1; i >= 0; i--) begin
      if (v[i]) r = ORD_W'(i);
    end
    return r;
  endfunction

endpackage

### src/bba_datapath.sv
module bba_datapath #(
  parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bba_pkg::dp_cmd_t  ctl,
  output bba_pkg::dp_stat_t stat,
  input  logic              cmd,
  input  logic [15:0]       req_size,
  input  logic [9:0]        free_offset,
  output logic [2:0]        status,
  output logic [9:0]        block_offset,
  output logic [3:0]        block_order
);
  import bba_pkg::*;

  localparam int NW = POOL_ORDER + 1;
  localparam int DEPTH = 2 ** NW;
  localparam int TDEPTH = 2 ** POOL_ORDER;
  localparam logic [ORD_W-1:0] P_ORD = ORD_W'(POOL_ORDER);

  logic [NW-1:0] mask_mem [DEPTH];
  logic [ORD_W-1:0] tag_mem [TDEPTH];

  logic [NW-1:0] clr;
  logic [NW-1:0] h;
  logic [NW-1:0] hsave;
  logic [ORD_W-1:0] k;
  logic [ORD_W-1:0] want;
  logic [ORD_W-1:0] tgt;
  logic [POOL_ORDER-1:0] off;
  logic [NW-1:0] m;
  logic op_free;
  logic zero;
  logic too_big;
  logic [NW-1:0] mrd;
  logic [ORD_W-1:0] trd;
  logic [2:0] pend_status;
  logic [POOL_ORDER-1:0] pend_off;
  logic [ORD_W-1:0] pend_ord;

  logic [31:0] fo_ext;
  logic [31:0] po_ext;
  logic [POOL_ORDER-1:0] in_off;
  logic [ORD_W-1:0] want_in;
  logic [NW-1:0] above;
  logic [NW-1:0] rng;
  logic [ORD_W-1:0] rng_hi;
  logic [ORD_W-1:0] km1;
  logic [ORD_W-1:0] tag_ord;
  logic [NW-1:0] fnode;
  logic [ORD_W-1:0] lowest;
  logic [NW-1:0] sh_k;
  logic [NW-1:0] sh_tgt;

  logic mwe;
  logic [NW-1:0] mwaddr;
  logic [NW-1:0] mwdata;
  logic [NW-1:0] mraddr;
  logic twe;
  logic [POOL_ORDER-1:0] twaddr;
  logic [ORD_W-1:0] twdata;

  assign fo_ext = 32'(free_offset);
  assign in_off = fo_ext[POOL_ORDER-1:0];
  assign po_ext = 32'(pend_off);
  assign want_in = ceil_log2(req_size);
  assign km1 = k - ORD_W'(1);
  assign rng_hi = (ctl.op == OP_SLEFT) ? km1 : tgt;
  assign tag_ord = trd - ORD_W'(1);
  assign fnode = (NW'(1) << (P_ORD - tag_ord)) + NW'(off >> tag_ord);
  assign lowest = lowest_bit(MAX_W'(above));
  assign sh_k = mrd >> k;
  assign sh_tgt = mrd >> tgt;

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      above[i] = mrd[i] && (ORD_W'(i) >= want);
      rng[i] = (ORD_W'(i) >= want) && (ORD_W'(i) < rng_hi);
    end
  end

  assign stat.clr_last   = &clr;
  assign stat.is_free    = op_free;
  assign stat.zero       = zero;
  assign stat.too_big    = too_big;
  assign stat.tag_bad    = (trd == '0) || (trd > P_ORD + ORD_W'(1));
  assign stat.root_has   = |above;
  assign stat.k_eq_tgt   = (k == tgt);
  assign stat.k_top      = (k == P_ORD);
  assign stat.k_eq_want  = (k == want);
  assign stat.buddy_free = sh_k[0];

  always_comb begin
    mwe = 1'b0;
    mwaddr = h;
    mwdata = '0;
    twe = 1'b0;
    twaddr = off;
    twdata = '0;
    case (ctl.op)
      OP_CLEAR: begin
        mwe = 1'b1;
        mwaddr = clr;
        mwdata = (clr == NW'(1)) ? (NW'(1) << POOL_ORDER) : '0;
        twe = 1'b1;
        twaddr = clr[POOL_ORDER-1:0];
      end
      OP_SAVE: begin
        mwe = 1'b1;
        mwdata = rng;
      end
      OP_UWR: begin
        mwe = 1'b1;
        mwaddr = h >> 1;
        mwdata = m | mrd;
      end
      OP_SRIGHT: begin
        mwe = 1'b1;
        mwaddr = (h << 1) | NW'(1);
        mwdata = NW'(1) << km1;
      end
      OP_SLEFT: begin
        mwe = 1'b1;
        mwaddr = h << 1;
        mwdata = rng;
      end
      OP_SLEAF: begin
        twe = 1'b1;
        twdata = want + ORD_W'(1);
      end
      OP_FSTART: begin
        twe = 1'b1;
      end
      OP_MZB: begin
        mwe = 1'b1;
        mwaddr = h ^ NW'(1);
      end
      OP_MZH: begin
        mwe = 1'b1;
      end
      OP_MFIN: begin
        mwe = 1'b1;
        mwdata = NW'(1) << k;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (ctl.op)
      OP_LOAD:  mraddr = NW'(1);
      OP_DREAD: mraddr = h << 1;
      OP_UREAD: mraddr = h ^ NW'(1);
      default:  mraddr = h;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mwe) mask_mem[mwaddr] <= mwdata;
    mrd <= mask_mem[mraddr];
    if (twe) tag_mem[twaddr] <= twdata;
    if (ctl.op == OP_LOAD) trd <= tag_mem[in_off];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (ctl.op == OP_CLEAR) begin
      clr <= clr + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        op_free <= (cmd == CMD_FREE);
        zero <= (req_size == 16'd0);
        too_big <= (want_in > P_ORD);
        want <= want_in;
        off <= in_off;
      end
      OP_FIND: begin
        tgt <= lowest;
        h <= NW'(1);
        k <= P_ORD;
        off <= '0;
      end
      OP_DSEL: begin
        if (sh_tgt[0]) begin
          h <= h << 1;
        end else begin
          h <= (h << 1) | NW'(1);
          off <= off | (POOL_ORDER'(1) << km1);
        end
        k <= km1;
      end
      OP_SAVE: begin
        hsave <= h;
        m <= rng;
      end
      OP_UWR: begin
        m <= m | mrd;
        h <= h >> 1;
        k <= k + ORD_W'(1);
      end
      OP_SPREP: begin
        h <= hsave;
        k <= tgt;
      end
      OP_SLEFT: begin
        h <= h << 1;
        k <= km1;
      end
      OP_SLEAF: begin
        pend_status <= ST_OK;
        pend_off <= off;
        pend_ord <= want;
      end
      OP_FSTART: begin
        k <= tag_ord;
        h <= fnode;
      end
      OP_MZH: begin
        h <= h >> 1;
        k <= k + ORD_W'(1);
        off <= off & ~(POOL_ORDER'(1) << k);
      end
      OP_MFIN: begin
        m <= NW'(1) << k;
        pend_status <= ST_OK;
        pend_off <= off;
        pend_ord <= k;
      end
      OP_SETERR: begin
        pend_status <= ctl.err;
        pend_off <= '0;
        pend_ord <= '0;
      end
      OP_EMIT: begin
        status <= pend_status;
        block_offset <= po_ext[9:0];
        block_order <= pend_ord[3:0];
      end
      default: begin
      end
    endcase
  end

endmodule

### src/bba_ctrl.sv
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t  ctl
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DESC,
    S_DSEL,
    S_UP,
    S_UWR,
    S_SPL,
    S_SLEFT,
    S_MRD,
    S_MCHK,
    S_MZH,
    S_MFIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic emit;

  assign in_ready = (state == S_IDLE);
  assign emit = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    ctl.op = OP_NONE;
    ctl.err = ST_OK;
    case (state)
      S_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.op = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_free) begin
          if (stat.tag_bad) begin
            ctl.op = OP_SETERR;
            ctl.err = ST_BADFREE;
            state_next = S_DONE;
          end else begin
            ctl.op = OP_FSTART;
            state_next = S_MRD;
          end
        end else if (stat.zero) begin
          ctl.op = OP_SETERR;
          ctl.err = ST_ZERO;
          state_next = S_DONE;
        end else if (stat.too_big) begin
          ctl.op = OP_SETERR;
          ctl.err = ST_LARGE;
          state_next = S_DONE;
        end else if (!stat.root_has) begin
          ctl.op = OP_SETERR;
          ctl.err = ST_NOSPACE;
          state_next = S_DONE;
        end else begin
          ctl.op = OP_FIND;
          state_next = S_DESC;
        end
      end
      S_DESC: begin
        if (stat.k_eq_tgt) begin
          ctl.op = OP_SAVE;
          state_next = S_UP;
        end else begin
          ctl.op = OP_DREAD;
          state_next = S_DSEL;
        end
      end
      S_DSEL: begin
        ctl.op = OP_DSEL;
        state_next = S_DESC;
      end
      S_UP: begin
        if (!stat.k_top) begin
          ctl.op = OP_UREAD;
          state_next = S_UWR;
        end else if (stat.is_free) begin
          state_next = S_DONE;
        end else begin
          ctl.op = OP_SPREP;
          state_next = S_SPL;
        end
      end
      S_UWR: begin
        ctl.op = OP_UWR;
        state_next = S_UP;
      end
      S_SPL: begin
        if (stat.k_eq_want) begin
          ctl.op = OP_SLEAF;
          state_next = S_DONE;
        end else begin
          ctl.op = OP_SRIGHT;
          state_next = S_SLEFT;
        end
      end
      S_SLEFT: begin
        ctl.op = OP_SLEFT;
        state_next = S_SPL;
      end
      S_MRD: begin
        if (stat.k_top) begin
          state_next = S_MFIN;
        end else begin
          ctl.op = OP_UREAD;
          state_next = S_MCHK;
        end
      end
      S_MCHK: begin
        if (stat.buddy_free) begin
          ctl.op = OP_MZB;
          state_next = S_MZH;
        end else begin
          state_next = S_MFIN;
        end
      end
      S_MZH: begin
        ctl.op = OP_MZH;
        state_next = S_MRD;
      end
      S_MFIN: begin
        ctl.op = OP_MFIN;
        state_next = S_UP;
      end
      S_DONE: begin
        if (emit) begin
          ctl.op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/buddy_block_allocator.sv
// an allocation descends from the root to the found order, climbs back to the root and then
//   splits down to the requested order; a free merges while its buddy is free, then climbs
//   to the root; an error walks no tree; a held result stalls the request in flight
// one request in flight; in_ready rises in the same cycle as out_valid for its result
// reset: a clearing pass over every mask and tag entry runs first, in_ready stays low
//   until it ends; afterwards only the whole pool is free
module buddy_block_allocator #(
  parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] req_size,
  input  logic [9:0]  free_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [9:0]  block_offset,
  output logic [3:0]  block_order
);
  import bba_pkg::*;

  `include "buddy_block_allocator_defines.svh"

  dp_cmd_t ctl;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  bba_datapath #(
    .POOL_ORDER (POOL_ORDER)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cmd          (cmd),
    .req_size     (req_size),
    .free_offset  (free_offset),
    .status       (status),
    .block_offset (block_offset),
    .block_order  (block_order)
  );

  // error results carry no block
  `BBA_ASSERT_NEVER(a_err_zero, out_valid && (status != ST_OK) && ((block_offset != 10'd0) || (block_order != 4'd0)), "error result with nonzero block")
  // one request in flight
  `BBA_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "request accepted while busy")

endmodule
